### sv/tasl_pkg.sv
// Package with the shared types and constants of the tachometer block.
`timescale 1ns / 1ps
`default_nettype none

package tasl_pkg;

    localparam int PERIOD_W = 16;
    localparam int CYL_W    = 4;
    localparam int FILT_W   = 4;
    localparam int THR_W    = 14;
    localparam int RPM_W    = 16;
    localparam int SUM_W    = 23;
    localparam int CNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int DIV_W = 27;
    localparam int DSR_W = PERIOD_W + CYL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [DIV_W-1:0]  RPM_NUMERATOR = DIV_W'(120000000);
    localparam logic [THR_W-1:0]  HYSTERESIS    = THR_W'(100);
    localparam logic [FILT_W-1:0] FILT_MIN      = FILT_W'(1);
    localparam logic [FILT_W-1:0] FILT_MAX      = FILT_W'(10);

    localparam logic [CYL_W-1:0]  CYL_RESET  = CYL_W'(4);
    localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(1);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5000);

    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_THRESHOLD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RPM,
        ST_ACCUM,
        ST_DIV_AVG,
        ST_PUBLISH,
        ST_DONE
    } tasl_state_t;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic accumulate;
        logic publish;
        logic finish;
    } tasl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic avg_due;
    } tasl_status_t;

endpackage
`default_nettype wire

### sv/tasl_div.sv
// Restoring divider that produces one quotient bit per cycle while step is asserted.
`timescale 1ns / 1ps
`default_nettype none

module tasl_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [tasl_pkg::DIV_W-1:0]  dividend,
    input  wire logic [tasl_pkg::DSR_W-1:0]  divisor,
    output logic      [tasl_pkg::DIV_W-1:0]  quotient,
    output logic                             last
);

    logic [tasl_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [tasl_pkg::DSR_W-1:0]     rem_reg, rem_next;
    logic [tasl_pkg::DSR_W-1:0]     dsr_reg, dsr_next;
    logic [tasl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tasl_pkg::DSR_W:0]       trial;
    logic [tasl_pkg::DSR_W:0]       diff;

    always_comb begin
        trial    = {rem_reg, quo_reg[tasl_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (load) begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = tasl_pkg::DIV_CNT_W'(tasl_pkg::DIV_W - 1);
        end else if (step) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[tasl_pkg::DSR_W-1:0];
                quo_next = {quo_reg[tasl_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[tasl_pkg::DSR_W-1:0];
                quo_next = {quo_reg[tasl_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - tasl_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == '0);

endmodule
`default_nettype wire

### sv/tasl_datapath.sv
// Datapath: configuration registers, RPM sum, averaging, shift light and result register.
`timescale 1ns / 1ps
`default_nettype none

module tasl_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire tasl_pkg::tasl_cmd_t             cmd,
    output tasl_pkg::tasl_status_t               status,
    input  wire logic                            cfg_write,
    input  wire logic [tasl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tasl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [tasl_pkg::PERIOD_W-1:0]   s_pulse_period,
    input  wire logic                            s_overflow,
    output logic      [tasl_pkg::RPM_W-1:0]      m_rpm,
    output logic                                 m_shift_light,
    output logic                                 m_average_ready
);

    logic [tasl_pkg::CYL_W-1:0]  cyl_reg;
    logic [tasl_pkg::FILT_W-1:0] filt_reg;
    logic [tasl_pkg::THR_W-1:0]  thr_reg;

    logic [tasl_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [tasl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [tasl_pkg::RPM_W-1:0]  rpm_value_reg, rpm_value_next;
    logic                        light_reg, light_next;
    logic                        ovf_reg;
    logic                        zero_div_reg;
    logic                        ready_reg;
    logic [tasl_pkg::RPM_W-1:0]  out_rpm_reg;
    logic                        out_light_reg;
    logic                        out_ready_reg;

    logic [tasl_pkg::DSR_W-1:0]  product;
    logic [tasl_pkg::FILT_W-1:0] level;
    logic [tasl_pkg::CNT_W-1:0]  target;
    logic [tasl_pkg::RPM_W-1:0]  instant;
    logic [tasl_pkg::SUM_W-1:0]  sum_add;
    logic [tasl_pkg::CNT_W-1:0]  count_inc;
    logic                        avg_due;
    logic [tasl_pkg::RPM_W-1:0]  rpm_final;
    logic [tasl_pkg::THR_W-1:0]  off_level;

    logic                        div_load;
    logic [tasl_pkg::DIV_W-1:0]  div_dividend;
    logic [tasl_pkg::DSR_W-1:0]  div_divisor;
    logic [tasl_pkg::DIV_W-1:0]  quotient;
    logic                        div_last;

    tasl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (div_load),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    always_comb begin
        product = s_overflow ? '0
                : tasl_pkg::DSR_W'(s_pulse_period) * tasl_pkg::DSR_W'(cyl_reg);

        if (filt_reg < tasl_pkg::FILT_MIN) begin
            level = tasl_pkg::FILT_MIN;
        end else if (filt_reg > tasl_pkg::FILT_MAX) begin
            level = tasl_pkg::FILT_MAX;
        end else begin
            level = filt_reg;
        end
        target = {level, 3'b000} + {2'b00, level, 1'b0};

        if (zero_div_reg) begin
            instant = '0;
        end else if (quotient[tasl_pkg::DIV_W-1:tasl_pkg::RPM_W] != '0) begin
            instant = '1;
        end else begin
            instant = quotient[tasl_pkg::RPM_W-1:0];
        end
        sum_add   = sum_reg + tasl_pkg::SUM_W'(instant);
        count_inc = count_reg + tasl_pkg::CNT_W'(1);
        avg_due   = (count_inc >= target);

        div_load     = cmd.capture || (cmd.accumulate && avg_due);
        div_dividend = cmd.capture ? tasl_pkg::RPM_NUMERATOR : tasl_pkg::DIV_W'(sum_add);
        div_divisor  = cmd.capture ? product : tasl_pkg::DSR_W'(target);

        rpm_final = ovf_reg ? '0 : rpm_value_reg;
        off_level = (thr_reg >= tasl_pkg::HYSTERESIS) ? thr_reg - tasl_pkg::HYSTERESIS : '0;
        light_next = light_reg;
        if (rpm_final >= tasl_pkg::RPM_W'(thr_reg)) begin
            light_next = 1'b1;
        end
        if (rpm_final <= tasl_pkg::RPM_W'(off_level)) begin
            light_next = 1'b0;
        end

        sum_next       = sum_reg;
        count_next     = count_reg;
        rpm_value_next = rpm_value_reg;
        if (cmd.accumulate) begin
            sum_next   = avg_due ? '0 : sum_add;
            count_next = avg_due ? '0 : count_inc;
        end
        if (cmd.publish) begin
            rpm_value_next = quotient[tasl_pkg::RPM_W-1:0];
        end
        if (cmd.finish) begin
            rpm_value_next = rpm_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ovf_reg      <= s_overflow;
            zero_div_reg <= (product == '0);
        end
        if (cmd.accumulate) begin
            ready_reg <= avg_due;
        end
        if (cmd.finish) begin
            out_rpm_reg   <= rpm_final;
            out_light_reg <= light_next;
            out_ready_reg <= ready_reg;
        end
        if (!aresetn) begin
            cyl_reg       <= tasl_pkg::CYL_RESET;
            filt_reg      <= tasl_pkg::FILT_RESET;
            thr_reg       <= tasl_pkg::THR_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            rpm_value_reg <= '0;
            light_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    tasl_pkg::CFG_CYLINDER_COUNT: begin
                        cyl_reg <= cfg_data[tasl_pkg::CYL_W-1:0];
                    end
                    tasl_pkg::CFG_FILTER_LEVEL: begin
                        filt_reg <= cfg_data[tasl_pkg::FILT_W-1:0];
                    end
                    tasl_pkg::CFG_SHIFT_THRESHOLD: begin
                        thr_reg <= cfg_data[tasl_pkg::THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            rpm_value_reg <= rpm_value_next;
            if (cmd.finish) begin
                light_reg <= light_next;
            end
        end
    end

    assign status.div_last = div_last;
    assign status.avg_due  = avg_due;
    assign m_rpm           = out_rpm_reg;
    assign m_shift_light   = out_light_reg;
    assign m_average_ready = out_ready_reg;

endmodule
`default_nettype wire

### sv/tasl_ctrl.sv
// Controller state machine that sequences the divisions and the result handshake.
`timescale 1ns / 1ps
`default_nettype none

module tasl_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire tasl_pkg::tasl_status_t status,
    output tasl_pkg::tasl_cmd_t        cmd
);

    tasl_pkg::tasl_state_t state_reg, state_next;
    logic                  valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tasl_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            tasl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = tasl_pkg::ST_DIV_RPM;
                end
            end
            tasl_pkg::ST_DIV_RPM: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = tasl_pkg::ST_ACCUM;
                end
            end
            tasl_pkg::ST_ACCUM: begin
                cmd.accumulate = 1'b1;
                state_next = status.avg_due ? tasl_pkg::ST_DIV_AVG : tasl_pkg::ST_DONE;
            end
            tasl_pkg::ST_DIV_AVG: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = tasl_pkg::ST_PUBLISH;
                end
            end
            tasl_pkg::ST_PUBLISH: begin
                cmd.publish = 1'b1;
                state_next  = tasl_pkg::ST_DONE;
            end
            tasl_pkg::ST_DONE: begin
                if (!valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = tasl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tasl_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = valid_reg;

endmodule
`default_nettype wire

### sv/tachometer_average_shift_light_top.sv
// Top level of the period-based tachometer with averaging and shift light.
//
// Each input beat on s_ carries one captured pulse period in microsecond
// ticks and the timer overflow flag. Every input beat yields exactly one
// result beat on m_ with the published RPM, the shift light and a flag that
// marks a freshly completed average.
// A sample that does not close an average passes through one division for
// the instantaneous RPM before the result is valid; one that does passes
// through a second division for the average as well. A new input beat is
// taken in the cycle after the previous result is loaded. Both divisions
// run on the shared bit-serial divider, the instantaneous RPM first and
// the average after it.
// The result register holds a finished beat while the receiver stalls, and
// the next input beat is still taken; its own result waits until the
// register is free.
// Reset restores cylinder_count 4, filter_level 1, shift_threshold 5000,
// clears the running sum, count, published RPM and light, and drops m_valid.
// Configuration beats are always taken and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module tachometer_average_shift_light_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tasl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tasl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tasl_pkg::PERIOD_W-1:0]   s_pulse_period,
    input  wire logic                            s_overflow,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [tasl_pkg::RPM_W-1:0]      m_rpm,
    output logic                                 m_shift_light,
    output logic                                 m_average_ready
);

    tasl_pkg::tasl_cmd_t    cmd;
    tasl_pkg::tasl_status_t status;

    assign cfg_ready = 1'b1;

    tasl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tasl_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_pulse_period  (s_pulse_period),
        .s_overflow      (s_overflow),
        .m_rpm           (m_rpm),
        .m_shift_light   (m_shift_light),
        .m_average_ready (m_average_ready)
    );

endmodule
`default_nettype wire

### sv/tasl_checker.sv
// Port-level checker for the tachometer block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tasl_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [tasl_pkg::RPM_W-1:0] m_rpm,
    input wire logic                       m_shift_light,
    input wire logic                       m_average_ready
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input taken while an item is in work.");

    a_zero_rpm_light_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rpm == '0 |-> !m_shift_light)
        else $error("Shift light lit at zero RPM.");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rpm) && $stable(m_shift_light)
            && $stable(m_average_ready))
        else $error("Stalled result beat changed.");

endmodule

bind tachometer_average_shift_light_top tasl_checker u_tasl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_rpm           (m_rpm),
    .m_shift_light   (m_shift_light),
    .m_average_ready (m_average_ready)
);

`default_nettype wire

### dv/tach_result_checker.sv
// Checker that predicts the tachometer result beats and compares them with the block.
`timescale 1ns / 1ps

module tach_result_checker
    import tasl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [PERIOD_W-1:0]   s_pulse_period,
    input  wire logic                  s_overflow,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [RPM_W-1:0]      m_rpm,
    input  wire logic                  m_shift_light,
    input  wire logic                  m_average_ready,
    output int                         pending,
    output int                         fails
);

    localparam int unsigned PULSE_NUMERATOR = 120_000_000;
    localparam int unsigned RPM_CEILING     = 65535;
    localparam int unsigned LIGHT_BAND      = 100;
    localparam int unsigned BEATS_PER_LEVEL = 10;
    localparam int unsigned LEVEL_MAX       = 10;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             lamp;
        logic             average_ready;
    } tach_result_t;

    logic [CYL_W-1:0]  cyl_cfg;
    logic [FILT_W-1:0] filt_cfg;
    logic [THR_W-1:0]  thr_cfg;
    logic [SUM_W-1:0]  rpm_acc;
    logic [CNT_W-1:0]  acc_count;
    logic [RPM_W-1:0]  shown_rpm;
    logic              light_lit;
    tach_result_t      expected_q[$];
    int                fail_cnt = 0;

    function automatic logic [RPM_W-1:0] period_to_rpm(input logic [PERIOD_W-1:0] period,
                                                       input logic [CYL_W-1:0] cyl);
        int unsigned divisor;
        int unsigned quot;
        divisor = period * cyl;
        if (divisor == 0) begin
            return '0;
        end
        quot = PULSE_NUMERATOR / divisor;
        return (quot > RPM_CEILING) ? RPM_W'(RPM_CEILING) : RPM_W'(quot);
    endfunction

    function automatic tach_result_t predict_sample(input logic [PERIOD_W-1:0] period,
                                                    input logic ovf);
        int unsigned       level;
        int unsigned       target;
        int unsigned       off_level;
        logic [PERIOD_W-1:0] used;
        tach_result_t      res;
        level = filt_cfg;
        if (level == 0) begin
            level = 1;
        end
        if (level > LEVEL_MAX) begin
            level = LEVEL_MAX;
        end
        target = level * BEATS_PER_LEVEL;
        used = ovf ? '0 : period;
        res.average_ready = 1'b0;
        rpm_acc = rpm_acc + SUM_W'(period_to_rpm(used, cyl_cfg));
        acc_count = acc_count + CNT_W'(1);
        if (acc_count >= target) begin
            shown_rpm = RPM_W'(rpm_acc / target);
            rpm_acc = '0;
            acc_count = '0;
            res.average_ready = 1'b1;
        end
        if (ovf) begin
            shown_rpm = '0;
        end
        off_level = (thr_cfg >= LIGHT_BAND) ? thr_cfg - LIGHT_BAND : 0;
        if (shown_rpm >= thr_cfg) begin
            light_lit = 1'b1;
        end
        if (shown_rpm <= off_level) begin
            light_lit = 1'b0;
        end
        res.rpm = shown_rpm;
        res.lamp = light_lit;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        tach_result_t want;
        if (!aresetn) begin
            cyl_cfg = CYL_RESET;
            filt_cfg = FILT_RESET;
            thr_cfg = THR_RESET;
            rpm_acc = '0;
            acc_count = '0;
            shown_rpm = '0;
            light_lit = 1'b0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no expected result: rpm %0d", m_rpm);
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_rpm !== want.rpm) begin
                        $error("rpm mismatch: expected %0d, actual %0d", want.rpm, m_rpm);
                        fail_cnt++;
                    end
                    if (m_shift_light !== want.lamp) begin
                        $error("m_shift_light mismatch: expected %0d, actual %0d",
                               want.lamp, m_shift_light);
                        fail_cnt++;
                    end
                    if (m_average_ready !== want.average_ready) begin
                        $error("average_ready mismatch: expected %0d, actual %0d",
                               want.average_ready, m_average_ready);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CYLINDER_COUNT: begin
                        cyl_cfg = cfg_data[CYL_W-1:0];
                    end
                    CFG_FILTER_LEVEL: begin
                        filt_cfg = cfg_data[FILT_W-1:0];
                    end
                    CFG_SHIFT_THRESHOLD: begin
                        thr_cfg = cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_sample(s_pulse_period, s_overflow));
            end
        end
        pending <= expected_q.size();
        fails <= fail_cnt;
    end

endmodule

### dv/tb_tachometer_average_shift_light_top.sv
// Testbench top that drives samples and register writes into the tachometer block.
`timescale 1ns / 1ps

module tb_tachometer_average_shift_light_top;
    import tasl_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SINK_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct {
        int cyl;
        int filt;
        int thr;
        int count;
        bit hold;
    } setting_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PERIOD_W-1:0]   s_pulse_period = '0;
    logic                  s_overflow = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [RPM_W-1:0]      m_rpm;
    logic                  m_shift_light;
    logic                  m_average_ready;

    int   pending;
    int   fails;
    int   quiet_cycles = 0;
    logic calm = 1'b0;
    logic stall_req = 1'b0;

    always begin
        aclk = 1'b0;
        #(CLK_HALF);
        aclk = 1'b1;
        #(CLK_HALF);
    end

    tachometer_average_shift_light_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pulse_period  (s_pulse_period),
        .s_overflow      (s_overflow),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rpm           (m_rpm),
        .m_shift_light   (m_shift_light),
        .m_average_ready (m_average_ready)
    );

    tach_result_checker u_result_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pulse_period  (s_pulse_period),
        .s_overflow      (s_overflow),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rpm           (m_rpm),
        .m_shift_light   (m_shift_light),
        .m_average_ready (m_average_ready),
        .pending         (pending),
        .fails           (fails)
    );

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end
        if (pick < 85) begin
            return $urandom_range(1, 3);
        end
        if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PERIOD_W-1:0] rpm_to_period(input int rpm, input int cyl);
        int eff;
        int p;
        eff = (cyl == 0) ? 1 : cyl;
        if (rpm < 1) begin
            rpm = 1;
        end
        p = 120_000_000 / (rpm * eff);
        if (p > 65535) begin
            p = 65535;
        end
        if (p < 1) begin
            p = 1;
        end
        return PERIOD_W'(p);
    endfunction

    task automatic send_sample(input logic [PERIOD_W-1:0] period, input logic ovf);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pulse_period <= period;
        s_overflow <= ovf;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_sample(input setting_t phase, input int center);
        int                  pick;
        logic [PERIOD_W-1:0] period;
        logic                ovf;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            period = rpm_to_period(center + int'($urandom_range(0, 100)) - 50, phase.cyl);
        end else if (pick < 68) begin
            period = '0;
        end else if (pick < 76) begin
            period = PERIOD_W'($urandom_range(1, 2000));
        end else if (pick < 94) begin
            period = PERIOD_W'($urandom_range(0, 65535));
        end else begin
            period = '1;
        end
        ovf = ($urandom_range(0, 19) == 0);
        send_sample(period, ovf);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input setting_t phase);
        logic [CFG_DATA_W-1:0] word;
        write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        word = CFG_DATA_W'($urandom);
        word[CYL_W-1:0] = CYL_W'(phase.cyl);
        write_reg(CFG_CYLINDER_COUNT, word);
        word = CFG_DATA_W'($urandom);
        word[FILT_W-1:0] = FILT_W'(phase.filt);
        write_reg(CFG_FILTER_LEVEL, word);
        write_reg(CFG_SHIFT_THRESHOLD, CFG_DATA_W'(phase.thr));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : sink
        int idle_left;
        int hold_cnt;
        idle_left = 0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= SINK_HOLD) begin
                    stall_req = 1'b0;
                    hold_cnt = 0;
                end
            end else if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0) begin
                    idle_left = idle_len();
                end
            end
        end
    end

    initial begin : stimulus
        setting_t plan[$];
        setting_t cur;
        int       center;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: four cylinders, ten-sample average, threshold 5000.
        repeat (8) send_sample(16'd6000, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd458, 1'b0);
        send_sample(16'd457, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'd12345, 1'b1);
        repeat (3) send_sample(16'd6000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        drain_results();

        plan.push_back('{2, 1, 100, 80, 1'b0});
        plan.push_back('{8, 10, 10000, 120, 1'b0});
        // The filter drops to two while twenty samples are still summed.
        plan.push_back('{8, 2, 10000, 40, 1'b0});
        plan.push_back('{0, 0, 0, 50, 1'b0});
        plan.push_back('{15, 15, 16383, 100, 1'b0});
        plan.push_back('{6, 3, 50, 80, 1'b0});
        plan.push_back('{4, 1, 5000, 100, 1'b1});
        repeat (4) begin
            cur.cyl = 2 * $urandom_range(1, 4);
            cur.filt = $urandom_range(1, 10);
            cur.thr = $urandom_range(100, 10000);
            cur.count = 90;
            cur.hold = 1'b0;
            plan.push_back(cur);
        end

        foreach (plan[p]) begin
            apply_setting(plan[p]);
            calm = ($urandom_range(0, 3) == 0);
            if (plan[p].hold) begin
                stall_req = 1'b1;
            end
            center = plan[p].thr;
            for (int i = 0; i < plan[p].count; i++) begin
                if (i % 10 == 0) begin
                    center = plan[p].thr + int'($urandom_range(0, 800)) - 400;
                end
                random_sample(plan[p], center);
            end
            drain_results();
        end

        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
